// File: rtl/depth_sorted_insert_list_top_macros.svh
// ----------------------------------------------------------------------------
// Depth-sorted insert list assertion macros
// Concurrent check shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_SORTED_INSERT_LIST_TOP_MACROS_SVH
`define DEPTH_SORTED_INSERT_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSIL_CHK_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSIL_CHK_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/dsil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted insert list package
// Beat types, operation and status codes, and controller interface structs.
// ----------------------------------------------------------------------------
package dsil_pkg;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned TOTAL_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_MOVE   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        item_handle;
    logic signed [31:0] depth_key;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [TOTAL_W-1:0] entry_total;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_RECMP = 4'b0100,
    ST_REINS = 4'b1000
  } state_e;

  typedef struct packed {
    logic capture;
    logic recompare;
    logic do_ins;
    logic do_rem;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       found;
  } stat_t;

endpackage

// File: rtl/dsil_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted insert list controller
// Sequences capture, remove, recompare and insert steps and owns the beat
// handshakes on both channels.
// ----------------------------------------------------------------------------
module dsil_ctrl
  import dsil_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.op == OP_MOVE && stat_i.found) begin
          cmd_o.do_rem = 1'b1;
          state_d      = ST_RECMP;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.do_ins   = (stat_i.op == OP_INSERT);
          cmd_o.do_rem   = (stat_i.op == OP_REMOVE);
          state_d        = ST_IDLE;
        end
      end
      ST_RECMP: begin
        cmd_o.recompare = 1'b1;
        state_d         = ST_REINS;
      end
      ST_REINS: begin
        if (out_free) begin
          cmd_o.do_ins   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/dsil_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted insert list datapath
// Row of compare-and-shift cells with the entry count, the registered compare
// vectors and the result register.
// ----------------------------------------------------------------------------
module dsil_dpath
  import dsil_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_data_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output out_t  out_data_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] VEC_ONE = CAPACITY'(1);

  logic [15:0]        cell_handle_q [CAPACITY];
  logic signed [31:0] cell_depth_q  [CAPACITY];

  logic [1:0]         op_q;
  logic [15:0]        handle_q;
  logic signed [31:0] depth_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAPACITY-1:0] ge_q, match_q;
  logic [CAPACITY-1:0] ge_cmp, match_cmp, ins_vec, dec_vec, below_vec, first_vec;
  logic signed [31:0] key;
  logic               full, found;
  out_t               out_q, res;

  function automatic logic [IDX_W-1:0] encode(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (v[i]) begin
        r = r | IDX_W'(i);
      end
    end
    return r;
  endfunction

  assign key   = cmd_i.capture ? in_data_i.depth_key : depth_q;
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign found = |match_q;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_cmp[i]    = !(count_q > CNT_W'(i)) || (cell_depth_q[i] > key);
      match_cmp[i] = (count_q > CNT_W'(i)) && (cell_handle_q[i] == in_data_i.item_handle);
    end
  end

  assign dec_vec   = match_q - VEC_ONE;
  assign below_vec = dec_vec & ~match_q;
  assign first_vec = match_q & ~dec_vec;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign ins_vec[g] = !full && ge_q[g];
    end else begin : g_body
      assign ins_vec[g] = !full && ge_q[g] && !ge_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.do_ins && !full) begin
        if (ins_vec[g]) begin
          cell_handle_q[g] <= handle_q;
          cell_depth_q[g]  <= depth_q;
        end else if (ge_q[g]) begin
          cell_handle_q[g] <= cell_handle_q[(g == 0) ? 0 : g - 1];
          cell_depth_q[g]  <= cell_depth_q[(g == 0) ? 0 : g - 1];
        end
      end else if (cmd_i.do_rem && found && !below_vec[g] && (g < CAPACITY - 1)) begin
        cell_handle_q[g] <= cell_handle_q[(g < CAPACITY - 1) ? g + 1 : g];
        cell_depth_q[g]  <= cell_depth_q[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_ins && !full) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.do_rem && found) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    res.status      = STAT_OK;
    res.position    = '0;
    res.entry_total = TOTAL_W'(count_d);
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          res.position = POS_W'(encode(ins_vec));
        end
      end
      OP_REMOVE: begin
        if (found) begin
          res.position = POS_W'(encode(first_vec));
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      OP_MOVE: begin
        if (found) begin
          res.position = POS_W'(encode(ins_vec));
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        res.status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_data_i.opcode;
      handle_q <= in_data_i.item_handle;
      depth_q  <= in_data_i.depth_key;
      ge_q     <= ge_cmp;
      match_q  <= match_cmp;
    end else if (cmd_i.recompare) begin
      ge_q <= ge_cmp;
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  assign stat_o.op    = op_q;
  assign stat_o.found = found;
  assign out_data_o   = out_q;

endmodule

// File: rtl/depth_sorted_insert_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted insert list
// Bounded list of (handle, depth) entries kept in ascending depth order.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Beat
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (opcode, handle, depth)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (status, position, total)
//
//  Insert, remove, unused opcodes and a move that misses take the accept and
//  execute steps. A move that finds its handle takes the accept, remove shift,
//  recompare and insert shift steps.
//  The cell row compares every entry at once, so the entry count adds no steps.
//  A stalled output holds the final step until the result register frees up.
//  Reset clears the entry count and the output valid; the cells need no clearing.
// ----------------------------------------------------------------------------
module depth_sorted_insert_list_top
  import dsil_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  dsil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsil_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/dsil_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted insert list checker
// Port-level checks on input and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "depth_sorted_insert_list_top_macros.svh"

module dsil_chk
  import dsil_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic out_held;
  logic out_failed;
  logic out_full;
  logic in_taken;
  logic pos_zero;
  logic total_cap;

  assign out_held   = out_valid_o && out_stall_i;
  assign out_failed = out_valid_o && (out_data_o.status != STAT_OK);
  assign out_full   = out_valid_o && (out_data_o.status == STAT_FULL);
  assign in_taken   = in_valid_i && !in_stall_o;
  assign pos_zero   = (out_data_o.position == '0);
  assign total_cap  = (out_data_o.entry_total == TOTAL_W'(CAPACITY));

  `DSIL_CHK_NEXT(a_out_valid, clk_i, rst_ni, out_held, out_valid_o, "stalled beat dropped")

  `DSIL_CHK_NEXT(a_out_data, clk_i, rst_ni, out_held, $stable(out_data_o), "beat changed in stall")

  `DSIL_CHK_NOW(a_fail_pos, clk_i, rst_ni, out_failed, pos_zero, "failed beat has a position")

  `DSIL_CHK_NOW(a_full_total, clk_i, rst_ni, out_full, total_cap, "full without a full list")

  `DSIL_CHK_NEXT(a_in_busy, clk_i, rst_ni, in_taken, in_stall_o, "no stall after a beat")

endmodule

bind depth_sorted_insert_list_top dsil_chk #(
  .CAPACITY (CAPACITY)
) u_dsil_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: test/depth_sorted_insert_list_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted insert list testbench
// Sends insert, remove, move and spare-opcode beats with random gaps and
// output stalls. A sorted list kept in the testbench predicts each result
// beat, and every field is checked against it.
// ----------------------------------------------------------------------------
module depth_sorted_insert_list_top_tb;
  import dsil_pkg::*;

  localparam int unsigned LIST_CAP     = 64;
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam int unsigned RANDOM_BEATS = 1150;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD    = 400;

  localparam int unsigned MIX_FILL  = 0;
  localparam int unsigned MIX_CHURN = 1;
  localparam int unsigned MIX_DRAIN = 2;
  localparam int unsigned MIX_NOISE = 3;

  class sorted_list_model;
    logic [15:0]        handles[$];
    logic signed [31:0] depths[$];
    out_t               pending_results[$];
    int unsigned        fail_count;

    function int place_entry(logic [15:0] handle, logic signed [31:0] depth);
      int pos;
      pos = 0;
      while (pos < handles.size() && depths[pos] <= depth) pos++;
      handles.insert(pos, handle);
      depths.insert(pos, depth);
      return pos;
    endfunction

    function void note_request(in_t req);
      out_t res;
      int   idx;
      int   pos;
      res        = '0;
      res.status = STAT_OK;
      pos        = 0;
      idx        = -1;
      case (req.opcode)
        OP_INSERT: begin
          if (handles.size() >= LIST_CAP) begin
            res.status = STAT_FULL;
          end else begin
            pos = place_entry(req.item_handle, req.depth_key);
          end
        end
        OP_REMOVE, OP_MOVE: begin
          foreach (handles[i]) begin
            if (idx < 0 && handles[i] == req.item_handle) idx = i;
          end
          if (idx < 0) begin
            res.status = STAT_NOT_FOUND;
          end else begin
            handles.delete(idx);
            depths.delete(idx);
            if (req.opcode == OP_REMOVE) begin
              pos = idx;
            end else begin
              pos = place_entry(req.item_handle, req.depth_key);
            end
          end
        end
        default: begin
        end
      endcase
      res.position    = pos[POS_W-1:0];
      res.entry_total = TOTAL_W'(handles.size());
      pending_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $error("result beat %h arrived with no request outstanding", got);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        fail_count++;
      end
      if (got.entry_total !== want.entry_total) begin
        $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  sorted_list_model sb = new();
  int unsigned      next_gap = 0;
  int unsigned      idle_cycles = 0;
  bit               quiet_sender = 1'b0;
  bit               long_hold_req = 1'b0;

  depth_sorted_insert_list_top #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The gap before the next beat is drawn at acceptance, so valid drops right away
  // when a gap follows and stays high for back-to-back beats.
  task automatic send_beat(input in_t req);
    if (next_gap > 0) repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    next_gap = quiet_sender ? 0 : $urandom_range(0, 14);
    if (next_gap > 0) in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    if (next_gap == 0) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
    next_gap = 0;
  endtask

  function automatic in_t pack_request(logic [1:0] op, logic [15:0] handle,
                                       logic signed [31:0] depth);
    in_t req;
    req.opcode      = op;
    req.item_handle = handle;
    req.depth_key   = depth;
    return req;
  endfunction

  function automatic in_t random_request(int unsigned mix);
    in_t         req;
    int unsigned roll;
    roll            = $urandom_range(0, 99);
    req.item_handle = 16'($urandom);
    req.depth_key   = $urandom;
    case (mix)
      MIX_FILL: begin
        req.opcode = roll < 80 ? OP_INSERT : roll < 92 ? OP_MOVE :
                     roll < 97 ? OP_REMOVE : OP_SPARE;
      end
      MIX_CHURN: begin
        req.opcode = roll < 40 ? OP_INSERT : roll < 70 ? OP_REMOVE :
                     roll < 95 ? OP_MOVE : OP_SPARE;
      end
      MIX_DRAIN: begin
        req.opcode = roll < 15 ? OP_INSERT : roll < 85 ? OP_REMOVE :
                     roll < 97 ? OP_MOVE : OP_SPARE;
      end
      default: begin
        req.opcode = 2'($urandom_range(0, 3));
      end
    endcase
    if (mix != MIX_NOISE) begin
      roll = $urandom_range(0, 99);
      if (roll < 70 && sb.handles.size() > 0) begin
        req.item_handle = sb.handles[$urandom_range(0, sb.handles.size() - 1)];
      end else if (roll < 90) begin
        req.item_handle = 16'($urandom_range(0, 15));
      end
      roll = $urandom_range(0, 99);
      if (roll < 30 && sb.depths.size() > 0) begin
        req.depth_key = sb.depths[$urandom_range(0, sb.depths.size() - 1)];
      end else if (roll < 70) begin
        req.depth_key = 32'($urandom_range(0, 8) << 16) - 32'h0004_0000;
      end else if (roll < 76) begin
        req.depth_key = roll[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
    end
    return req;
  endfunction

  initial begin
    int unsigned hold;
    bit          quiet_receiver;
    quiet_receiver = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = quiet_receiver ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
      if ($urandom_range(0, 39) == 0) quiet_receiver = !quiet_receiver;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[depth_sorted_insert_list_top] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned mix;
    int unsigned random_sent;
    phase       = 0;
    random_sent = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: lookups miss and the spare opcode only reports the count.
    send_beat(pack_request(OP_REMOVE, 16'h0000, 32'sh0));
    send_beat(pack_request(OP_MOVE, 16'hFFFF, 32'sh7FFF_FFFF));
    send_beat(pack_request(OP_SPARE, 16'h0000, 32'sh0));
    send_beat(pack_request(OP_INSERT, 16'h0000, 32'sh0));
    send_beat(pack_request(OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF));
    send_beat(pack_request(OP_INSERT, 16'h1234, 32'sh8000_0000));
    // Equal depths go after the entries already there.
    send_beat(pack_request(OP_INSERT, 16'h0001, 32'sh0));
    send_beat(pack_request(OP_INSERT, 16'h0001, -32'sh1));
    send_beat(pack_request(OP_INSERT, 16'hABCD, 32'sh7FFF_FFFF));
    // Duplicate handles: remove and move act on the first one only.
    send_beat(pack_request(OP_REMOVE, 16'h0001, 32'sh5555_5555));
    send_beat(pack_request(OP_MOVE, 16'h0001, 32'sh8000_0000));
    send_beat(pack_request(OP_MOVE, 16'hFFFF, 32'sh8000_0000));
    send_beat(pack_request(OP_MOVE, 16'h0000, 32'sh7FFF_FFFF));
    send_beat(pack_request(OP_SPARE, 16'hFFFF, 32'shFFFF_FFFF));
    send_beat(pack_request(OP_REMOVE, 16'h5555, 32'sh0));
    send_beat(pack_request(OP_MOVE, 16'hAAAA, 32'sh0001_0000));
    send_beat(pack_request(OP_INSERT, 16'h5A5A, 32'sh0001_0000));
    send_beat(pack_request(OP_INSERT, 16'hA5A5, -32'sh0001_0000));
    send_beat(pack_request(OP_REMOVE, 16'h1234, 32'shAAAA_AAAA));
    send_beat(pack_request(OP_MOVE, 16'hABCD, 32'sh0));
    send_beat(pack_request(OP_REMOVE, 16'hFFFF, 32'sh0));
    wait_for_drain();

    while (random_sent < RANDOM_BEATS) begin
      mix          = $urandom_range(0, 3);
      phase_len    = $urandom_range(20, 90);
      quiet_sender = ($urandom_range(0, 3) == 0);
      // Hold the output back while beats keep coming, so the block fills and stalls.
      if (phase == 2 || phase == 12) begin
        long_hold_req = 1'b1;
        quiet_sender  = 1'b1;
        mix           = MIX_FILL;
        phase_len     = 120;
      end
      repeat (phase_len) begin
        if (random_sent < RANDOM_BEATS) begin
          send_beat(random_request(mix));
          random_sent++;
        end
      end
      if (phase == 3 || $urandom_range(0, 4) == 0) wait_for_drain();
      phase++;
    end

    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("[depth_sorted_insert_list_top] OK");
    end else begin
      $display("[depth_sorted_insert_list_top] ERROR");
    end
    $finish;
  end

endmodule

// File: depth_sorted_insert_list_top.f
+incdir+rtl
rtl/dsil_pkg.sv
rtl/dsil_ctrl.sv
rtl/dsil_dpath.sv
rtl/depth_sorted_insert_list_top.sv
rtl/dsil_chk.sv
test/depth_sorted_insert_list_top_tb.sv
